// ----- rtl/hamcf_pkg.sv -----
package hamcf_pkg;

	localparam int ACTION_W = 2;
	localparam int FIELD_W  = 8;
	localparam int NUM_DATA = 4;
	localparam int IDX_W    = 4;

	localparam logic [ACTION_W-1:0] ACT_SPEED  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADDR   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STATUS = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic [7:0] CH_START       = 8'h24;
	localparam logic [7:0] CH_END         = 8'h21;
	localparam logic [7:0] CH_DIGIT_OFS   = 8'h30;
	localparam logic [7:0] CH_LETTER_OFS  = 8'h37;
	localparam logic [7:0] OPC_ADDR_CHG   = 8'h0B;
	localparam logic [7:0] SPEED_PAD      = 8'h00;

	localparam logic [IDX_W-1:0] LAST_IDX_LONG  = 4'd9;
	localparam logic [IDX_W-1:0] LAST_IDX_SHORT = 4'd5;

	// four data bytes, sent as two hex digits each; short frames use two
	typedef struct packed {
		logic                            long_frame;
		logic [NUM_DATA-1:0][FIELD_W-1:0] data;
	} frame_desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'h0, nib};
		return (nib >= 4'd10) ? ext + CH_LETTER_OFS : ext + CH_DIGIT_OFS;
	endfunction

endpackage

// ----- rtl/hamcf_cmd_if.sv -----
interface hamcf_cmd_if
	import hamcf_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [FIELD_W-1:0]  address;
	logic [FIELD_W-1:0]  value;

	modport source (output valid, action, address, value, input ready);
	modport sink (input valid, action, address, value, output ready);
endinterface

// ----- rtl/hamcf_byte_if.sv -----
interface hamcf_byte_if
	import hamcf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] tx_byte;
	logic               last;

	modport source (output valid, tx_byte, last, input ready);
	modport sink (input valid, tx_byte, last, output ready);
endinterface

// ----- rtl/hex_ascii_motor_command_framer.sv -----
// Turns each command word (set speed, change address, request status) into a motor-controller
// frame sent one ASCII word per cycle while the receiver is ready: '$', data bytes as two
// uppercase hex digits, then '!' with last set. Set-speed and change-address frames are 10
// bytes, status requests 6; the output byte is registered and frames follow with no gap.
// Unused action code 3 is accepted and yields no output. A two-entry queue sits between the
// command stage and the byte sequencer, so commands are accepted while a frame drains, until full.
module hex_ascii_motor_command_framer
	import hamcf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hamcf_cmd_if.sink    cmd,
	hamcf_byte_if.source frame
);

	logic        fq_valid;
	logic        fq_ready;
	frame_desc_t fq_data;
	logic        bq_valid;
	logic        bq_ready;
	frame_desc_t bq_data;

	hamcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data)
	);

	hamcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (bq_valid),
		.pop_ready (bq_ready),
		.pop_data  (bq_data)
	);

	hamcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(bq_valid),
		.pop_ready(bq_ready),
		.pop_data (bq_data),
		.frame    (frame)
	);

endmodule

// ----- rtl/hamcf_front.sv -----
module hamcf_front
	import hamcf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	hamcf_cmd_if.sink     cmd,
	output logic          push_valid,
	input  logic          push_ready,
	output frame_desc_t   push_data
);

	logic        valid_s1;
	frame_desc_t desc_s1;
	frame_desc_t desc_d;
	logic        accept;
	logic [FIELD_W-1:0] csum;

	assign cmd.ready  = !valid_s1 || push_ready;
	assign accept     = cmd.valid && cmd.ready;
	assign push_valid = valid_s1;
	assign push_data  = desc_s1;
	assign csum       = cmd.address + cmd.value;

	always_comb begin
		desc_d = '0;
		desc_d.data[0] = cmd.address;
		unique case (cmd.action)
			ACT_SPEED: begin
				desc_d.long_frame = 1'b1;
				desc_d.data[1] = cmd.value;
				desc_d.data[2] = SPEED_PAD;
				desc_d.data[3] = csum;
			end
			ACT_ADDR: begin
				desc_d.long_frame = 1'b1;
				desc_d.data[1] = OPC_ADDR_CHG;
				desc_d.data[2] = cmd.value;
				desc_d.data[3] = cmd.value;
			end
			ACT_STATUS: begin
				desc_d.long_frame = 1'b0;
				desc_d.data[1] = cmd.address;
			end
			default: begin
				desc_d.long_frame = 1'b0;
			end
		endcase
	end

	// unused action code is taken and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (cmd.action != ACT_UNUSED);
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

// ----- rtl/hamcf_queue.sv -----
module hamcf_queue
	import hamcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  frame_desc_t push_data,
	output logic        pop_valid,
	input  logic        pop_ready,
	output frame_desc_t pop_data
);

	frame_desc_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/hamcf_back.sv -----
module hamcf_back
	import hamcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  frame_desc_t pop_data,
	hamcf_byte_if.source frame
);

	frame_desc_t      cur_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       tx_q;
	logic             last_q;

	logic             can_adv;
	logic [IDX_W-1:0] idx_m1;
	logic [IDX_W-1:0] last_idx;
	logic             emit_last;
	logic [7:0]       cur_byte;
	logic [3:0]       nib;
	logic [7:0]       emit_byte;
	logic             load;

	assign can_adv   = !out_valid_q || frame.ready;
	assign load      = can_adv && !busy_q && pop_valid;
	assign pop_ready = can_adv && !busy_q;

	assign idx_m1    = idx_q - 4'd1;
	assign last_idx  = cur_q.long_frame ? LAST_IDX_LONG : LAST_IDX_SHORT;
	assign emit_last = (idx_q == last_idx);
	// position 1 onward: two digits per data byte, high nibble first
	assign cur_byte  = cur_q.data[idx_m1[2:1]];
	assign nib       = idx_m1[0] ? cur_byte[3:0] : cur_byte[7:4];
	assign emit_byte = emit_last ? CH_END : hex_digit(nib);

	assign frame.valid   = out_valid_q;
	assign frame.tx_byte = tx_q;
	assign frame.last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (can_adv) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 4'd1;
				if (emit_last) begin
					busy_q <= 1'b0;
				end
			end else if (pop_valid) begin
				// the start mark is registered at the same edge the frame is loaded
				out_valid_q <= 1'b1;
				busy_q      <= 1'b1;
				idx_q       <= 4'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= pop_data;
		end
		if (can_adv) begin
			if (busy_q) begin
				tx_q   <= emit_byte;
				last_q <= emit_last;
			end else begin
				tx_q   <= CH_START;
				last_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/hamcf_checker.sv -----
module hamcf_checker
	import hamcf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_byte,
	input logic       tx_last
);

	logic expect_start_q;
	logic tx_hex;

	// next word out must open a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_start_q <= 1'b1;
		end else if (tx_valid && tx_ready) begin
			expect_start_q <= tx_last;
		end
	end

	assign tx_hex = (tx_byte >= 8'h30 && tx_byte <= 8'h39) ||
		(tx_byte >= 8'h41 && tx_byte <= 8'h46);

	a_last_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> (tx_last == (tx_byte == CH_END)))
		else $error("last flag does not match closing word");

	a_frame_opens: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && expect_start_q |-> tx_byte == CH_START)
		else $error("frame does not open with start mark");

	a_frame_body: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !expect_start_q |-> tx_hex || tx_byte == CH_END)
		else $error("illegal word inside frame");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("stalled output word changed");

endmodule

bind hex_ascii_motor_command_framer hamcf_checker u_hamcf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.tx_valid(frame.valid),
	.tx_ready(frame.ready),
	.tx_byte (frame.tx_byte),
	.tx_last (frame.last)
);
